@@ sv/abdf_pkg.sv @@
// package: types, tables and sigmoid for the anchor box decode filter
`timescale 1ns / 1ps
package abdf_pkg;

    localparam int MaxGrid = 256;
    localparam int QueueDepth = 4;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sw;
        logic [15:0] sh;
        logic [15:0] score;
        logic [7:0]  gx;
        logic [7:0]  gy;
        logic [1:0]  scale;
        logic [1:0]  anchor;
    } cls_item_t;

    typedef struct packed {
        logic signed [19:0] left;
        logic signed [19:0] top;
        logic signed [19:0] right;
        logic signed [19:0] bottom;
        logic [15:0]        score;
    } box_item_t;

    function automatic logic [15:0] sigm(input logic signed [15:0] x);
        logic [15:0] a;
        logic [16:0] p;
        begin
            a = x[15] ? 16'(-x) : 16'(x);
            if (a < 16'd4096)
                p = 17'({a, 2'b00}) + 17'd32768;
            else if (a < 16'd9728)
                p = 17'({a, 1'b0}) + 17'd40960;
            else if (a < 16'd20480)
                p = 17'(a >> 1) + 17'd55296;
            else
                p = 17'd65536;
            if (x[15])
                sigm = 16'(17'd65536 - p);
            else
                sigm = p[16] ? 16'hffff : p[15:0];
        end
    endfunction

    function automatic logic [5:0] stride_of(input logic [1:0] sc);
        case (sc)
            2'd0:    stride_of = 6'd8;
            2'd1:    stride_of = 6'd16;
            default: stride_of = 6'd32;
        endcase
    endfunction

    // {width, height} in pixels
    function automatic logic [17:0] anchor_of(input logic [1:0] sc, input logic [1:0] an);
        case ({sc, an})
            4'h0:    anchor_of = {9'd4, 9'd5};
            4'h1:    anchor_of = {9'd8, 9'd10};
            4'h2:    anchor_of = {9'd13, 9'd16};
            4'h4:    anchor_of = {9'd23, 9'd29};
            4'h5:    anchor_of = {9'd43, 9'd55};
            4'h6:    anchor_of = {9'd73, 9'd105};
            4'h8:    anchor_of = {9'd146, 9'd217};
            4'h9:    anchor_of = {9'd231, 9'd300};
            default: anchor_of = {9'd335, 9'd433};
        endcase
    endfunction

endpackage

@@ sv/abdf_front.sv @@
// front end: sigmoid, score and threshold filter, two stages
`timescale 1ns / 1ps
module abdf_front import abdf_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [15:0]       thr,
    input  logic [15:0]       raw_x,
    input  logic [15:0]       raw_y,
    input  logic [15:0]       raw_w,
    input  logic [15:0]       raw_h,
    input  logic [15:0]       raw_obj,
    input  logic [15:0]       raw_cls,
    input  logic [7:0]        grid_x,
    input  logic [7:0]        grid_y,
    input  logic [1:0]        scale,
    input  logic [1:0]        anchor,
    output logic              out_valid,
    output cls_item_t         out_item
);
    logic        s1_valid_reg;
    cls_item_t   s1_item_reg;
    logic [15:0] s1_cls_reg;
    logic        s1_ok;
    logic [15:0] obj;
    logic [31:0] prod;
    logic        s2_valid_reg;
    cls_item_t   s2_item_reg;
    cls_item_t   s2_item_next;

    assign obj = sigm(raw_obj);
    assign s1_ok = (scale != 2'd3) && (anchor != 2'd3) && (32'(grid_x) < MaxGrid)
        && (32'(grid_y) < MaxGrid) && (obj > thr);
    assign prod = s1_item_reg.score * s1_cls_reg;

    always_comb
    begin
        s2_item_next = s1_item_reg;
        s2_item_next.score = prod[31:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid && s1_ok;
            s2_valid_reg <= s1_valid_reg && (prod[31:16] > thr);
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= '{sx: sigm(raw_x), sy: sigm(raw_y), sw: sigm(raw_w),
            sh: sigm(raw_h), score: obj, gx: grid_x, gy: grid_y,
            scale: scale, anchor: anchor};
        s1_cls_reg <= sigm(raw_cls);
        s2_item_reg <= s2_item_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_item = s2_item_reg;
endmodule

@@ sv/abdf_queue.sv @@
// small queue between front and back ends
`timescale 1ns / 1ps
module abdf_queue import abdf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  cls_item_t wr_data,
    input  logic      rd_en,
    output logic      not_empty,
    output cls_item_t rd_data,
    output logic [$clog2(QueueDepth):0] count
);
    localparam int Aw = $clog2(QueueDepth);
    cls_item_t mem [QueueDepth];
    logic [Aw-1:0] wp_reg, rp_reg;
    logic [Aw:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (Aw+1)'(wr_en) - (Aw+1)'(rd_en);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    assign rd_data = mem[rp_reg];
    assign not_empty = cnt_reg != '0;
    assign count = cnt_reg;
endmodule

@@ sv/abdf_back.sv @@
// back end: box decode in two stages with output register
`timescale 1ns / 1ps
module abdf_back import abdf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  cls_item_t in_item,
    output logic      in_ready,
    input  logic      out_ready,
    output logic      out_valid,
    output box_item_t out_item
);
    logic        b1_valid_reg, o_valid_reg;
    logic signed [24:0] cx_reg, cy_reg;
    logic [31:0] ssw_reg, ssh_reg;
    logic [8:0]  aw_reg, ah_reg;
    logic [15:0] score_reg;
    box_item_t   o_item_reg;
    logic [5:0]  st;
    logic [17:0] anc;
    logic [21:0] fx, fy;
    logic [31:0] ssw, ssh;
    logic [40:0] hwp, hhp;
    logic signed [25:0] hw, hh;
    logic        adv1, adv2;

    function automatic logic signed [19:0] clamp20(input logic signed [25:0] v);
        if (v > 26'sd524287)
            clamp20 = 20'sd524287;
        else if (v < -26'sd524288)
            clamp20 = -20'sd524288;
        else
            clamp20 = v[19:0];
    endfunction

    assign adv2 = !o_valid_reg || out_ready;
    assign adv1 = !b1_valid_reg || adv2;
    assign in_ready = adv1;

    assign st = stride_of(in_item.scale);
    assign anc = anchor_of(in_item.scale, in_item.anchor);
    assign fx = in_item.sx * st;
    assign fy = in_item.sy * st;
    assign ssw = in_item.sw * in_item.sw;
    assign ssh = in_item.sh * in_item.sh;
    assign hwp = ssw_reg * aw_reg;
    assign hhp = ssh_reg * ah_reg;
    assign hw = 26'(hwp[40:27]);
    assign hh = 26'(hhp[40:27]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                b1_valid_reg <= in_valid;
            if (adv2)
                o_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cx_reg <= 25'(fx >> 11) - 25'(st) * 25'd8
                + 25'(in_item.gx) * 25'(st) * 25'd16;
            cy_reg <= 25'(fy >> 11) - 25'(st) * 25'd8
                + 25'(in_item.gy) * 25'(st) * 25'd16;
            ssw_reg <= ssw;
            ssh_reg <= ssh;
            aw_reg <= anc[17:9];
            ah_reg <= anc[8:0];
            score_reg <= in_item.score;
        end
        if (adv2)
        begin
            o_item_reg.left <= clamp20(26'(cx_reg) - hw);
            o_item_reg.top <= clamp20(26'(cy_reg) - hh);
            o_item_reg.right <= clamp20(26'(cx_reg) + hw);
            o_item_reg.bottom <= clamp20(26'(cy_reg) + hh);
            o_item_reg.score <= score_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_item = o_item_reg;
endmodule

@@ sv/anchor_box_decode_filter_top.sv @@
// Anchor box decode filter: one prediction per cycle accepted unless full; a surviving
// item passes two front stages, the queue and two back stages. full rises when the
// queue cannot absorb what the front stages still hold, so input stalls only under pop
// backpressure. The confidence threshold is written through cfg_we/cfg_data, reset 0.25.
`timescale 1ns / 1ps
module anchor_box_decode_filter_top import abdf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] raw_x,
    input  logic [15:0] raw_y,
    input  logic [15:0] raw_w,
    input  logic [15:0] raw_h,
    input  logic [15:0] raw_obj,
    input  logic [15:0] raw_cls,
    input  logic [7:0]  grid_x,
    input  logic [7:0]  grid_y,
    input  logic [1:0]  scale,
    input  logic [1:0]  anchor,
    input  logic        pop,
    output logic        empty,
    output logic [19:0] left,
    output logic [19:0] top,
    output logic [19:0] right,
    output logic [19:0] bottom,
    output logic [15:0] score
);
    logic [15:0] thr_reg;
    logic        f_valid, q_ne, b_ready, b_valid;
    logic [$clog2(QueueDepth):0] q_count;
    cls_item_t   f_item, q_item;
    box_item_t   b_item;
    logic        q_rd, accept;

    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 16'd16384;
        else if (cfg_we)
            thr_reg <= cfg_data;
    end

    // entries in flight in front stages must fit in the queue
    assign full = 32'(q_count) > QueueDepth - 3;

    abdf_front u_front (.clk, .rst_n, .in_valid(accept), .thr(thr_reg),
        .raw_x, .raw_y, .raw_w, .raw_h, .raw_obj, .raw_cls, .grid_x, .grid_y,
        .scale, .anchor, .out_valid(f_valid), .out_item(f_item));

    assign q_rd = q_ne && b_ready;

    abdf_queue u_queue (.clk, .rst_n, .wr_en(f_valid), .wr_data(f_item),
        .rd_en(q_rd), .not_empty(q_ne), .rd_data(q_item), .count(q_count));

    abdf_back u_back (.clk, .rst_n, .in_valid(q_ne), .in_item(q_item),
        .in_ready(b_ready), .out_ready(pop), .out_valid(b_valid), .out_item(b_item));

    assign empty = !b_valid;
    assign left = b_item.left;
    assign top = b_item.top;
    assign right = b_item.right;
    assign bottom = b_item.bottom;
    assign score = b_item.score;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(32'(q_count) == QueueDepth && f_valid && !q_rd)) else $error("queue overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(score)) else $error("result lost");
    a_score: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid |-> f_item.score > $past(thr_reg)) else $error("score below threshold");
endmodule
